// ===== rtl/xs128p_pkg.sv =====
// Shared types and constants of the bounded xorshift128+ integer core.
`default_nettype none
package xs128p_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned SpanW    = ValueW + 1;
  localparam int unsigned InDataW  = 200;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned StepCntW = $clog2(ValueW);

  localparam logic [WordW-1:0] FirstReset  = 64'h021f9c6a70ca0c24;
  localparam logic [WordW-1:0] SecondReset = 64'hbae766b26645aa22;

  localparam int unsigned ShiftA = 23;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 26;

  localparam logic [ValueW-1:0] MostNeg = 32'h8000_0000;
  localparam logic [ValueW-1:0] MostPos = 32'h7fff_ffff;

  // Operation codes carried on the input tuser.
  localparam logic OpDraw   = 1'b0;
  localparam logic OpReseed = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StHold
  } core_state_e;

  // Control from the top level to the remainder unit.
  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] dividend;
    logic [SpanW-1:0]  divisor;
  } rem_ctrl_t;

  // Status from the remainder unit back to the top level.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ValueW-1:0] remainder;
  } rem_stat_t;

endpackage
`default_nettype wire

// ===== rtl/xs128p_gen.sv =====
// Xorshift128+ state words with reseed and one-step advance.
`default_nettype none
module xs128p_gen (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          advance_i,
  input  wire logic                          load_i,
  input  wire logic [xs128p_pkg::WordW-1:0]  seed_first_i,
  input  wire logic [xs128p_pkg::WordW-1:0]  seed_second_i,
  output logic      [xs128p_pkg::ValueW-1:0] rnd_o
);
  import xs128p_pkg::*;

  logic [WordW-1:0] first_q, first_d;
  logic [WordW-1:0] second_q, second_d;
  logic [WordW-1:0] mix_a;
  logic [WordW-1:0] next_second;

  always_comb begin
    mix_a       = first_q ^ (first_q << ShiftA);
    next_second = mix_a ^ second_q ^ (mix_a >> ShiftB) ^ (second_q >> ShiftC);
    first_d     = first_q;
    second_d    = second_q;
    if (load_i) begin
      first_d  = seed_first_i;
      second_d = seed_second_i;
    end else if (advance_i) begin
      first_d  = second_q;
      second_d = next_second;
    end
  end

  // Only the low half of the output sum is ever used.
  assign rnd_o = next_second[ValueW-1:0] + second_q[ValueW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= FirstReset;
      second_q <= SecondReset;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xs128p_rem.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module xs128p_rem (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire xs128p_pkg::rem_ctrl_t ctrl_i,
  output xs128p_pkg::rem_stat_t      stat_o
);
  import xs128p_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0]   dvd_q, dvd_d;
  logic [SpanW-1:0]    div_q, div_d;
  logic [ValueW-1:0]   rem_q, rem_d;
  logic [SpanW-1:0]    trial;

  always_comb begin
    trial  = {rem_q, dvd_q[ValueW-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = ctrl_i.dividend;
      div_d  = ctrl_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits the value width.
      if (trial >= div_q) begin
        rem_d = ValueW'(trial - div_q);
      end else begin
        rem_d = trial[ValueW-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(ValueW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy      = busy_q;
  assign stat_o.done      = done_q;
  assign stat_o.remainder = rem_q;

endmodule
`default_nettype wire

// ===== rtl/xorshift128plus_bounded_int_core.sv =====
// Top level of the bounded random integer core built on xorshift128+.
//
// Input stream (s_axis): one beat is either a draw (tuser = 0) or a reseed
// (tuser = 1). A reseed loads both 64-bit generator words in the cycle it is
// accepted and gives no result. A draw orders the two bounds, advances the
// generator once and reduces the low 32 bits of its output modulo the span.
// Output stream (m_axis): one beat per draw with the 32-bit signed value.
//
// A draw's output beat turns valid once the bit-serial remainder unit (one
// dividend bit per cycle) has worked through every dividend bit and a finish
// step has added the lower bound. The input opens in the same cycle, so the
// core takes no new draw before it is through with the last; the remainder
// unit limits how often draws are taken. A new beat is taken once the draw is
// finished, even while the result still waits in the output register; a reseed keeps the input open.
//
// If the receiver stalls while a second result is finished, the core holds
// that result in the remainder unit and accepts nothing until it moves out.
// Reset restores the fixed generator words and empties the output register.
`default_nettype none
module xorshift128plus_bounded_int_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // From bit 0: lo_field[31:0], lower_given, hi_field[31:0], upper_given,
  // seed_first[63:0], seed_second[63:0], zero fill.
  input  wire logic [xs128p_pkg::InDataW-1:0]    s_axis_tdata_i,
  // op: 0 draw, 1 reseed.
  input  wire logic                              s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // From bit 0: value[31:0].
  output logic      [xs128p_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import xs128p_pkg::*;

  core_state_e state_q, state_d;

  logic              in_fire;
  logic              out_free;
  logic              load_out;
  logic              m_valid_q, m_valid_d;
  logic [ValueW-1:0] m_data_q, m_data_d;
  logic [ValueW-1:0] lo_q, lo_d;

  logic [ValueW-1:0] lo_field, hi_field;
  logic              lower_given, upper_given;
  logic [WordW-1:0]  seed_first, seed_second;
  logic [ValueW-1:0] lo_eff, hi_eff, lo_ord, hi_ord;
  logic [SpanW-1:0]  span;
  logic [ValueW-1:0] rnd;
  logic              gen_load, gen_advance;

  rem_ctrl_t rem_ctrl;
  rem_stat_t rem_stat;

  assign lo_field    = s_axis_tdata_i[31:0];
  assign lower_given = s_axis_tdata_i[32];
  assign hi_field    = s_axis_tdata_i[64:33];
  assign upper_given = s_axis_tdata_i[65];
  assign seed_first  = s_axis_tdata_i[129:66];
  assign seed_second = s_axis_tdata_i[193:130];

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    lo_eff = lower_given ? lo_field : MostNeg;
    hi_eff = upper_given ? hi_field : MostPos;
    if ($signed(hi_eff) < $signed(lo_eff)) begin
      lo_ord = hi_eff;
      hi_ord = lo_eff;
    end else begin
      lo_ord = lo_eff;
      hi_ord = hi_eff;
    end
    // Ordered bounds give a span from 1 up to 2^32.
    span = {hi_ord[ValueW-1], hi_ord} - {lo_ord[ValueW-1], lo_ord} + SpanW'(1);
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    gen_load        = 1'b0;
    gen_advance     = 1'b0;
    load_out        = 1'b0;
    lo_d            = lo_q;
    rem_ctrl.start    = 1'b0;
    rem_ctrl.dividend = rnd;
    rem_ctrl.divisor  = span;
    case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == OpReseed) begin
            gen_load = 1'b1;
          end else begin
            gen_advance    = 1'b1;
            rem_ctrl.start = 1'b1;
            lo_d           = lo_ord;
            state_d        = StRun;
          end
        end
      end
      StRun: begin
        if (rem_stat.done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = StIdle;
          end else begin
            state_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (load_out) begin
      m_valid_d = 1'b1;
      m_data_d  = rem_stat.remainder + lo_q;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    lo_q     <= lo_d;
  end

  xs128p_gen u_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (gen_advance && in_fire),
    .load_i        (gen_load && in_fire),
    .seed_first_i  (seed_first),
    .seed_second_i (seed_second),
    .rnd_o         (rnd)
  );

  xs128p_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rem_ctrl),
    .stat_o (rem_stat)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
`default_nettype wire

// ===== rtl/xs128p_chk.sv =====
// Port-level checker for the bounded xorshift128+ core, bound to the top level.
`default_nettype none
module xs128p_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic                              s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [xs128p_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import xs128p_pkg::*;

  // An output beat that is stalled stays offered.
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its value.
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output value changed while stalled");

  // A draw keeps the input closed while the remainder is worked out.
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OpDraw
    |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input taken during a draw");

  // A reseed finishes in the cycle it is taken.
  a_reseed_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OpReseed
    |=> s_axis_tready_o)
    else $error("reseed stalled the input");

  // A reseed gives no result: the output cannot turn valid right after one.
  a_reseed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == OpReseed
    && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result appeared after a reseed");

endmodule

bind xorshift128plus_bounded_int_core xs128p_chk u_xs128p_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
